[sv/fccm_pkg.sv]
// ----------------------------------------------------------------------------
// fccm_pkg
// Shared types and constants for the FAT16 cluster chain manager.
// ----------------------------------------------------------------------------
package fccm_pkg;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_ALLOC = 3'd2;
    localparam logic [2:0] OP_FREE  = 3'd3;
    localparam logic [2:0] OP_SEEK  = 3'd4;
    localparam logic [2:0] OP_LEN   = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_BROKEN = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_LIMIT  = 3'd4;

    localparam logic [1:0] CFG_USABLE = 2'd0;
    localparam logic [1:0] CFG_SPC    = 2'd1;
    localparam logic [1:0] CFG_BASE   = 2'd2;

    localparam logic [15:0] CHAIN_END  = 16'hFFF8;
    localparam logic [15:0] ALLOC_MARK = 16'hFFFF;
    localparam logic [15:0] FREE_ENTRY = 16'h0000;

    // table write data select
    localparam logic [1:0] WD_VAL  = 2'd0;
    localparam logic [1:0] WD_ZERO = 2'd1;
    localparam logic [1:0] WD_MARK = 2'd2;

    // cluster_out select
    localparam logic [1:0] CL_ZERO  = 2'd0;
    localparam logic [1:0] CL_CUR   = 2'd1;
    localparam logic [1:0] CL_RDATA = 2'd2;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       wr;
        logic [1:0] wsel;
        logic       cur_inc;
        logic       cur_link;
        logic       cnt_inc;
        logic       mul;
        logic       fin;
        logic [2:0] fin_status;
        logic [1:0] cl_sel;
        logic       cnt_en;
        logic       lba_en;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       in_chain;
        logic       in_range;
        logic       cnt_lim;
        logic       cnt_eq_skip;
        logic       scan_ok;
        logic       rdata_zero;
        logic       clr_last;
    } t_stat;

endpackage

[sv/fccm_dp.sv]
// ----------------------------------------------------------------------------
// fccm_dp
// Datapath: link table memory, walk registers, config registers, LBA math
// and result registers.
// ----------------------------------------------------------------------------
module fccm_dp #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fccm_pkg::t_cmd      i_cmd,
    output fccm_pkg::t_stat     o_stat,
    input  logic [2:0]          i_opcode,
    input  logic [15:0]         i_cluster_index,
    input  logic [15:0]         i_entry_value,
    input  logic [15:0]         i_skip_links,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_done,
    output logic [2:0]          o_status,
    output logic [15:0]         o_cluster_out,
    output logic [15:0]         o_link_count,
    output logic [31:0]         o_sector_address
);
    import fccm_pkg::*;

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

    logic [15:0] mem [TABLE_DEPTH];

    logic [2:0]  r_op;
    logic [15:0] r_val;
    logic [15:0] r_skip;
    logic [16:0] r_cur;
    logic [16:0] r_cnt;
    logic [15:0] r_rdata;
    logic [23:0] r_prod;
    logic [12:0] r_usable;
    logic [7:0]  r_spc;
    logic [31:0] r_base;
    logic        r_done;
    logic [2:0]  r_status;
    logic [15:0] r_cl;
    logic [15:0] r_cnt_out;
    logic [31:0] r_lba;

    logic [AW-1:0] addr;
    logic [15:0]   wdata;
    logic [15:0]   cnt_sat;
    logic [31:0]   lba_sum;

    assign addr = r_cur[AW-1:0];

    always_comb begin
        case (i_cmd.wsel)
            WD_VAL:  wdata = r_val;
            WD_MARK: wdata = ALLOC_MARK;
            default: wdata = FREE_ENTRY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[addr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[addr];
        end
    end

    assign cnt_sat = r_cnt[16] ? 16'hFFFF : r_cnt[15:0];
    assign lba_sum = r_base + {8'd0, r_prod} - {23'd0, r_spc, 1'b0};

    always_comb begin
        o_stat.op          = r_op;
        o_stat.in_chain    = (r_cur >= 17'd2) && (r_cur < {1'b0, CHAIN_END});
        o_stat.in_range    = r_cur < DEPTH17;
        o_stat.cnt_lim     = r_cnt >= DEPTH17;
        o_stat.cnt_eq_skip = r_cnt == {1'b0, r_skip};
        o_stat.scan_ok     = (r_cur < {4'd0, r_usable}) && (r_cur < DEPTH17);
        o_stat.rdata_zero  = r_rdata == FREE_ENTRY;
        o_stat.clr_last    = r_cur == (DEPTH17 - 17'd1);
    end

    // payload, product and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_val  <= i_entry_value;
            r_skip <= i_skip_links;
        end
        if (i_cmd.mul) begin
            r_prod <= r_cur[15:0] * r_spc;
        end
        if (i_cmd.fin) begin
            r_status  <= i_cmd.fin_status;
            r_cnt_out <= i_cmd.cnt_en ? cnt_sat : 16'd0;
            r_lba     <= i_cmd.lba_en ? lba_sum : 32'd0;
            case (i_cmd.cl_sel)
                CL_CUR:   r_cl <= r_cur[15:0];
                CL_RDATA: r_cl <= r_rdata;
                default:  r_cl <= 16'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= 17'd0;
            r_cnt    <= 17'd0;
            r_done   <= 1'b0;
            r_usable <= 13'd4096;
            r_spc    <= 8'd1;
            r_base   <= 32'd0;
        end else begin
            r_done <= i_cmd.fin;
            if (i_cmd.load) begin
                r_cur <= (i_opcode == OP_ALLOC) ? 17'd2 : {1'b0, i_cluster_index};
                r_cnt <= 17'd0;
            end else begin
                if (i_cmd.cur_inc) begin
                    r_cur <= r_cur + 17'd1;
                end else if (i_cmd.cur_link) begin
                    r_cur <= {1'b0, r_rdata};
                end
                if (i_cmd.cnt_inc) begin
                    r_cnt <= r_cnt + 17'd1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_USABLE: r_usable <= i_cfg_data[12:0];
                    CFG_SPC:    r_spc    <= i_cfg_data[7:0];
                    CFG_BASE:   r_base   <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_cluster_out    = r_cl;
    assign o_link_count     = r_cnt_out;
    assign o_sector_address = r_lba;

endmodule

[sv/fccm_ctrl.sv]
// ----------------------------------------------------------------------------
// fccm_ctrl
// Controller: table clear after reset, opcode dispatch, allocate scan and
// chain walk sequencing.
// ----------------------------------------------------------------------------
module fccm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fccm_pkg::t_stat  i_stat,
    output fccm_pkg::t_cmd   o_cmd
);
    import fccm_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_RDW   = 4'd3;
    localparam logic [3:0] S_ASCAN = 4'd4;
    localparam logic [3:0] S_AWAIT = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_WWAIT = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_LBA   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.wr      = 1'b1;
                cmd.wsel    = WD_ZERO;
                cmd.cur_inc = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_WRITE: begin
                        cmd.fin = 1'b1;
                        n_state = S_IDLE;
                        if (!i_stat.in_range) begin
                            cmd.fin_status = ST_RANGE;
                        end else begin
                            cmd.wr   = 1'b1;
                            cmd.wsel = WD_VAL;
                        end
                    end
                    OP_READ: begin
                        if (!i_stat.in_range) begin
                            cmd.fin        = 1'b1;
                            cmd.fin_status = ST_RANGE;
                            n_state        = S_IDLE;
                        end else begin
                            cmd.rd  = 1'b1;
                            n_state = S_RDW;
                        end
                    end
                    OP_ALLOC: n_state = S_ASCAN;
                    OP_FREE, OP_SEEK, OP_LEN: n_state = S_WALK;
                    default: begin
                        cmd.fin = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RDW: begin
                cmd.fin    = 1'b1;
                cmd.cl_sel = CL_RDATA;
                n_state    = S_IDLE;
            end
            S_ASCAN: begin
                if (i_stat.scan_ok) begin
                    cmd.rd  = 1'b1;
                    n_state = S_AWAIT;
                end else begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_FULL;
                    n_state        = S_IDLE;
                end
            end
            S_AWAIT: begin
                if (i_stat.rdata_zero) begin
                    cmd.wr     = 1'b1;
                    cmd.wsel   = WD_MARK;
                    cmd.fin    = 1'b1;
                    cmd.cl_sel = CL_CUR;
                    n_state    = S_IDLE;
                end else begin
                    cmd.cur_inc = 1'b1;
                    n_state     = S_ASCAN;
                end
            end
            S_WALK: begin
                cmd.cnt_en = 1'b1;
                cmd.cl_sel = (i_stat.op == OP_SEEK) ? CL_CUR : CL_ZERO;
                if (i_stat.op == OP_SEEK && i_stat.cnt_eq_skip) begin
                    n_state = S_MUL;
                end else if (!i_stat.in_chain) begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = (i_stat.op == OP_SEEK) ? ST_BROKEN : ST_OK;
                    n_state        = S_IDLE;
                end else if (!i_stat.in_range) begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_RANGE;
                    n_state        = S_IDLE;
                end else if (i_stat.op != OP_FREE && i_stat.cnt_lim) begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_LIMIT;
                    n_state        = S_IDLE;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_WWAIT;
                end
            end
            S_WWAIT: begin
                cmd.cur_link = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (i_stat.op == OP_FREE) begin
                    cmd.wr   = 1'b1;
                    cmd.wsel = WD_ZERO;
                end
                n_state = S_WALK;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_LBA;
            end
            S_LBA: begin
                cmd.fin    = 1'b1;
                cmd.cl_sel = CL_CUR;
                cmd.cnt_en = 1'b1;
                cmd.lba_en = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = r_state != S_IDLE;
    assign o_cmd = cmd;

endmodule

[sv/fat_cluster_chain_manager_top.sv]
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager_top
// FAT16 cluster chain table: write/read entry, allocate, free chain, seek
// and chain length over a single-port link table.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | start, busy          | i_opcode, i_cluster_index, i_entry_value,
//           |                      | i_skip_links
//  result   | o_done (1 cycle)     | o_status, o_cluster_out, o_link_count,
//           |                      | o_sector_address
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// Allocate scans the table one entry at a time and walks follow one link at
// a time, since the table has one read/write port; seek then does the LBA
// multiply and add. After reset the table is cleared one entry a cycle,
// with busy high until the last entry is cleared. Results show for one
// cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module fat_cluster_chain_manager_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_cluster_index,
    input  logic [15:0] i_entry_value,
    input  logic [15:0] i_skip_links,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_cluster_out,
    output logic [15:0] o_link_count,
    output logic [31:0] o_sector_address
);
    import fccm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    fccm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fccm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (i_opcode),
        .i_cluster_index  (i_cluster_index),
        .i_entry_value    (i_entry_value),
        .i_skip_links     (i_skip_links),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_cluster_out    (o_cluster_out),
        .o_link_count     (o_link_count),
        .o_sector_address (o_sector_address)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a pending item");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_lba_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_sector_address == 32'd0)
        else $error("sector address on failed item");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FAT16 cluster chain manager. A scoreboard
// keeps its own copy of the link table and the registers, predicts the
// result of every accepted item and checks the results in order. Stimulus
// is a directed pass over the corner cases followed by random chain build,
// walk and free sequences mixed with raw table noise under several register
// settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb;
    import fccm_pkg::*;

    localparam int FAT_DEPTH = 4096;
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] cluster;
        logic [15:0] links;
        logic [31:0] lba;
    } fat_result_t;

    class chain_scoreboard;
        logic [15:0] fat_links [FAT_DEPTH];
        logic [12:0] usable_entries;
        logic [7:0]  cluster_sectors;
        logic [31:0] data_base_lba;
        fat_result_t fat_result_q [$];
        fat_result_t latest;
        int          errors;
        int          checked;

        function new();
            foreach (fat_links[i]) fat_links[i] = FREE_ENTRY;
            usable_entries      = 13'd4096;
            cluster_sectors     = 8'd1;
            data_base_lba       = 32'd0;
            errors              = 0;
            checked             = 0;
        endfunction

        function bit in_chain(int unsigned c);
            return (c >= 2) && (c < CHAIN_END);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_USABLE: usable_entries = data[12:0];
                CFG_SPC:    cluster_sectors = data[7:0];
                CFG_BASE:   data_base_lba = data;
                default: ;
            endcase
        endfunction

        // apply one table operation to the local table and queue its result
        function void note_item(logic [2:0] op, logic [15:0] idx, logic [15:0] val,
                                logic [15:0] skip);
            fat_result_t r;
            int unsigned c, nx, lim, i, cnt;
            r   = '0;
            cnt = 0;
            c   = 32'(idx);
            case (op)
                OP_WRITE: begin
                    if (idx >= FAT_DEPTH) r.status = ST_RANGE;
                    else fat_links[idx] = val;
                end
                OP_READ: begin
                    if (idx >= FAT_DEPTH) r.status = ST_RANGE;
                    else r.cluster = fat_links[idx];
                end
                OP_ALLOC: begin
                    lim = (usable_entries > FAT_DEPTH) ? FAT_DEPTH : 32'(usable_entries);
                    r.status = ST_FULL;
                    for (i = 2; i < lim; i++) begin
                        if (fat_links[i] == FREE_ENTRY) begin
                            fat_links[i] = ALLOC_MARK;
                            r.cluster    = i[15:0];
                            r.status     = ST_OK;
                            break;
                        end
                    end
                end
                OP_FREE: begin
                    while (in_chain(c)) begin
                        if (c >= FAT_DEPTH) begin
                            r.status = ST_RANGE;
                            break;
                        end
                        nx = 32'(fat_links[c]);
                        fat_links[c] = FREE_ENTRY;
                        cnt++;
                        c = nx;
                    end
                end
                OP_SEEK: begin
                    for (i = 0; i < skip; i++) begin
                        if (!in_chain(c)) begin
                            r.status = ST_BROKEN;
                            break;
                        end
                        if (c >= FAT_DEPTH) begin
                            r.status = ST_RANGE;
                            break;
                        end
                        if (i >= FAT_DEPTH) begin
                            r.status = ST_LIMIT;
                            break;
                        end
                        c = 32'(fat_links[c]);
                    end
                    r.cluster = c[15:0];
                    cnt = i;
                    if (r.status == ST_OK)
                        r.lba = data_base_lba + (c - 2) * cluster_sectors;
                end
                OP_LEN: begin
                    while (in_chain(c)) begin
                        if (c >= FAT_DEPTH) begin
                            r.status = ST_RANGE;
                            break;
                        end
                        if (cnt >= FAT_DEPTH) begin
                            r.status = ST_LIMIT;
                            break;
                        end
                        cnt++;
                        c = 32'(fat_links[c]);
                    end
                    if (cnt > 32'hFFFF) cnt = 32'hFFFF;
                end
                default: ;
            endcase
            r.links = cnt[15:0];
            fat_result_q.push_back(r);
            latest = r;
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] st, logic [15:0] cl, logic [15:0] lk,
                                   logic [31:0] lba);
            fat_result_t e;
            if (fat_result_q.size() == 0) begin
                $error("result with no item outstanding: status %0d cluster 0x%0h", st, cl);
                errors++;
                return;
            end
            e = fat_result_q.pop_front();
            checked++;
            compare_field("status", 32'(e.status), 32'(st));
            compare_field("cluster_out", 32'(e.cluster), 32'(cl));
            compare_field("link_count", 32'(e.links), 32'(lk));
            compare_field("sector_address", e.lba, lba);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_opcode = '0;
    logic [15:0] i_cluster_index = '0;
    logic [15:0] i_entry_value = '0;
    logic [15:0] i_skip_links = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [15:0] o_cluster_out;
    logic [15:0] o_link_count;
    logic [31:0] o_sector_address;

    chain_scoreboard sb = new();
    int sender_idle_pct = 0;
    int items_sent = 0;
    int reg_writes = 0;

    fat_cluster_chain_manager_top #(
        .TABLE_DEPTH(FAT_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_cluster_index (i_cluster_index),
        .i_entry_value   (i_entry_value),
        .i_skip_links    (i_skip_links),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_cluster_out   (o_cluster_out),
        .o_link_count    (o_link_count),
        .o_sector_address(o_sector_address)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_result(o_status, o_cluster_out, o_link_count, o_sector_address);
    end

    initial begin
        #1000ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [15:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(63));
        if (r < 80) return rand16();
        if (r < 88) return 16'($urandom_range(4101, 4090));
        if (r < 94) return 16'($urandom_range(16'hFFFF, 16'hFFF6));
        return 16'($urandom_range(FAT_DEPTH - 1));
    endfunction

    // mostly forward links, so random tables rarely form loops
    function automatic logic [15:0] pick_link(logic [15:0] idx);
        int r;
        r = $urandom_range(99);
        if (r < 60 && idx < FAT_DEPTH - 8) return 16'(idx + $urandom_range(8, 1));
        if (r < 72) return 16'($urandom_range(16'hFFFF, 16'hFFF8));
        if (r < 80) return FREE_ENTRY;
        if (r < 84) return 16'($urandom_range(63));
        return rand16();
    endfunction

    function automatic logic [15:0] pick_skip();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(8));
        if (r < 85) return rand16();
        return 16'($urandom_range(4097, 4094));
    endfunction

    task automatic send_item(logic [2:0] op, logic [15:0] idx, logic [15:0] val,
                             logic [15:0] skip);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_opcode        <= op;
        i_cluster_index <= idx;
        i_entry_value   <= val;
        i_skip_links    <= skip;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(op, idx, val, skip);
        if (op <= OP_LEN) items_sent++;
    endtask

    // stop sending and let every outstanding item complete
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.fat_result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        reg_writes++;
    endtask

    task automatic chain_sequence();
        logic [15:0] clusters [$];
        int k, q, j;
        k = $urandom_range(6, 1);
        repeat (k) begin
            send_item(OP_ALLOC, rand16(), rand16(), rand16());
            if (sb.latest.status == ST_OK) clusters.push_back(sb.latest.cluster);
        end
        if (clusters.size() == 0) return;
        for (j = 0; j + 1 < clusters.size(); j++)
            send_item(OP_WRITE, clusters[j], clusters[j + 1], rand16());
        if ($urandom_range(1))
            send_item(OP_WRITE, clusters[clusters.size() - 1],
                      16'($urandom_range(16'hFFFF, 16'hFFF8)), rand16());
        q = $urandom_range(4, 1);
        repeat (q) begin
            j = $urandom_range(clusters.size() - 1);
            case ($urandom_range(3))
                0: send_item(OP_SEEK, clusters[0], rand16(),
                             16'($urandom_range(clusters.size() + 1)));
                1: send_item(OP_LEN, clusters[j], rand16(), rand16());
                2: send_item(OP_READ, clusters[j], rand16(), rand16());
                default: send_item(OP_SEEK, clusters[j], rand16(), pick_skip());
            endcase
        end
        j = $urandom_range(clusters.size() - 1);
        if ($urandom_range(9) < 7)
            send_item(OP_FREE, $urandom_range(1) ? clusters[0] : clusters[j],
                      rand16(), rand16());
    endtask

    task automatic noise_item();
        logic [2:0]  op;
        logic [15:0] idx;
        if ($urandom_range(15) == 0) op = 3'($urandom_range(7, 6));
        else op = 3'($urandom_range(OP_LEN));
        idx = pick_index();
        send_item(op, idx, (op == OP_WRITE) ? pick_link(idx) : rand16(), pick_skip());
    endtask

    task automatic run_phase(int n_items, int idle_pct);
        int target;
        sender_idle_pct = idle_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(9) < 7) chain_sequence();
            else noise_item();
        end
        settle();
    endtask

    task automatic directed_items();
        send_item(OP_READ, 16'd0, 16'hFFFF, 16'hFFFF);
        send_item(OP_READ, 16'd4095, 16'd0, 16'd0);
        send_item(OP_READ, 16'd4096, 16'd0, 16'd0);
        send_item(OP_WRITE, 16'hFFFF, 16'h1234, 16'd0);
        send_item(OP_WRITE, 16'd4095, ALLOC_MARK, 16'd0);
        send_item(OP_READ, 16'd4095, 16'd0, 16'd0);
        send_item(OP_ALLOC, 16'd0, 16'd0, 16'd0);
        send_item(OP_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_WRITE, 16'd2, 16'd3, 16'd0);
        send_item(OP_WRITE, 16'd3, CHAIN_END, 16'd0);
        send_item(OP_SEEK, 16'd2, 16'd0, 16'd0);
        send_item(OP_SEEK, 16'd2, 16'd0, 16'd2);
        send_item(OP_SEEK, 16'd2, 16'd0, 16'd3);
        send_item(OP_LEN, 16'd2, 16'd0, 16'd0);
        // chain that runs off the end of the table
        send_item(OP_WRITE, 16'd3, 16'd5000, 16'd0);
        send_item(OP_LEN, 16'd2, 16'd0, 16'd0);
        send_item(OP_SEEK, 16'd2, 16'd0, 16'd5);
        send_item(OP_FREE, 16'd2, 16'd0, 16'd0);
        // self loop hits the walk limit
        send_item(OP_WRITE, 16'd5, 16'd5, 16'd0);
        send_item(OP_LEN, 16'd5, 16'd0, 16'd0);
        send_item(OP_SEEK, 16'd5, 16'd0, 16'hFFFF);
        send_item(OP_SEEK, 16'd5, 16'd0, 16'd4096);
        send_item(OP_FREE, 16'd5, 16'd0, 16'd0);
        send_item(OP_FREE, 16'd0, 16'd0, 16'd0);
        send_item(OP_LEN, 16'hFFF7, 16'd0, 16'd0);
        send_item(OP_SEEK, 16'd1, 16'd0, 16'd0);
        send_item(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(3'd7, 16'd2, 16'd2, 16'd2);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        sender_idle_pct = 10;
        directed_items();
        settle();

        write_reg(CFG_USABLE, 32'd16);
        write_reg(CFG_SPC, 32'd128);
        write_reg(CFG_BASE, 32'hFFFF_FFFF);
        run_phase(250, 10);

        write_reg(CFG_USABLE, 32'h1FFF);
        write_reg(CFG_SPC, 32'd255);
        write_reg(CFG_BASE, $urandom);
        run_phase(150, 10);

        write_reg(CFG_SPC, 32'd0);
        write_reg(CFG_BASE, 32'd0);
        for (int v = 0; v < 3; v++) begin
            write_reg(CFG_USABLE, 32'(v));
            run_phase(15, 82);
        end

        write_reg(CFG_USABLE, 32'd40);
        write_reg(CFG_SPC, $urandom_range(128, 1));
        write_reg(CFG_BASE, $urandom);
        run_phase(245, 82);

        write_reg(CFG_USABLE, 32'd3);
        write_reg(CFG_UNMAPPED, $urandom);
        write_reg(CFG_SPC, 32'd1);
        write_reg(CFG_BASE, $urandom);
        run_phase(150, 0);

        write_reg(CFG_USABLE, {19'h7FFFF, 13'd4096});
        write_reg(CFG_SPC, $urandom_range(255));
        write_reg(CFG_BASE, $urandom);
        run_phase(260, 0);

        settle();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d table operations across %0d register writes, %0d results checked.",
                 items_sent, reg_writes, sb.checked);
        $display("Covered chain builds and frees, broken and looping walks, and full tables.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
